// ===== rtl/bfps_pkg.sv =====
// shared types and constants for the breadth-first parent search block
`timescale 1ns / 1ps

package bfps_pkg;

    // vertex numbers are 4-bit fields, so the graph holds every vertex they can name
    localparam int VERT_W       = 4;
    localparam int NUM_VERTICES = 2 ** VERT_W;

    typedef logic [VERT_W-1:0] vertex_t;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_RUN    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_REACHED   = 2'd0,
        STAT_ROOT      = 2'd1,
        STAT_UNREACHED = 2'd2
    } node_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_VISIT    = 5'b00010,
        ST_SCAN_RD  = 5'b00100,
        ST_SCAN_CHK = 5'b01000,
        ST_EMIT     = 5'b10000
    } seq_state_t;

endpackage

// ===== rtl/bfps_adj_ram.sv =====
// single-port adjacency list memory with registered read data
`timescale 1ns / 1ps

module bfps_adj_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       addr,
    input  bfps_pkg::vertex_t       wr_data,
    output bfps_pkg::vertex_t       rd_data
);

    bfps_pkg::vertex_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

// ===== rtl/breadth_first_parent_search.sv =====
// top level of the breadth-first parent search block
`timescale 1ns / 1ps

// channel  handshake              fields                               transfer when
// -------  ---------------------  -----------------------------------  -----------------------
// input    in_valid, in_stall     req_type, vertex, neighbor           in_valid && !in_stall
// output   out_valid, out_stall   node, parent_node, node_status, last out_valid && !out_stall
//
// append and clear are taken while idle and the input stays open for them
// a run walks the queue, reading and checking each list entry of every vertex reached,
//   then makes 16 result transfers; input is stalled for the whole run
// the single adjacency memory port paces the walk: an entry is checked before the next is read
// reset clears degree counts, visit marks and the sequencer; list contents are not cleared
// output stall only holds the current result, it never disturbs the walk state

module breadth_first_parent_search #(
    parameter int MAX_DEGREE = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [3:0]  vertex,
    input  logic [3:0]  neighbor,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  node,
    output logic [3:0]  parent_node,
    output logic [1:0]  node_status,
    output logic        last
);

    localparam int NV     = bfps_pkg::NUM_VERTICES;
    localparam int VW     = bfps_pkg::VERT_W;
    // degree counter holds 0..MAX_DEGREE, list index holds 0..MAX_DEGREE-1
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEPTH  = NV * MAX_DEGREE;
    localparam int ADDR_W = $clog2(DEPTH);

    // sequencer and walk registers
    bfps_pkg::seq_state_t state_reg, state_next;
    logic [VW:0]          head_reg, head_next;
    logic [VW:0]          tail_reg, tail_next;
    bfps_pkg::vertex_t    cur_reg, cur_next;
    bfps_pkg::vertex_t    start_reg, start_next;
    logic [DEG_W-1:0]     deg_reg, deg_next;
    logic [DEG_W-1:0]     k_reg, k_next;
    bfps_pkg::vertex_t    node_reg, node_next;

    // per-vertex state
    logic [DEG_W-1:0]     degree_reg [NV];
    logic [NV-1:0]        visited_reg;
    bfps_pkg::vertex_t    parent_reg [NV];
    bfps_pkg::vertex_t    fifo_reg [NV];

    // input transfer decode
    logic                 in_xfer;
    logic                 out_xfer;
    bfps_pkg::req_t       req;
    logic                 do_append;
    logic                 do_run;
    logic                 do_clear;

    // shared address unit: vertex * MAX_DEGREE + list index
    bfps_pkg::vertex_t    addr_vert;
    logic [IDX_W-1:0]     addr_idx;
    logic [ADDR_W-1:0]    ram_addr;
    logic                 ram_wr;
    bfps_pkg::vertex_t    ram_rd_data;

    // degree lookup, one address shared by append and dequeue
    bfps_pkg::vertex_t    deg_vert;
    logic [DEG_W-1:0]     deg_sel;
    bfps_pkg::vertex_t    head_vert;

    // walk step decode
    logic                 enqueue;

    assign req       = bfps_pkg::req_t'(req_type);
    assign in_stall  = (state_reg != bfps_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign do_append = in_xfer && (req == bfps_pkg::REQ_APPEND);
    assign do_run    = in_xfer && (req == bfps_pkg::REQ_RUN);
    assign do_clear  = in_xfer && (req == bfps_pkg::REQ_CLEAR);

    assign head_vert = fifo_reg[head_reg[VW-1:0]];
    assign deg_vert  = (state_reg == bfps_pkg::ST_IDLE) ? vertex : head_vert;
    assign deg_sel   = degree_reg[deg_vert];

    // appends write at the end of the named list, scans read the current list
    assign addr_vert = (state_reg == bfps_pkg::ST_IDLE) ? vertex : cur_reg;
    assign addr_idx  = (state_reg == bfps_pkg::ST_IDLE) ? deg_sel[IDX_W-1:0]
                                                        : k_reg[IDX_W-1:0];
    assign ram_addr  = ADDR_W'(addr_vert) * ADDR_W'(MAX_DEGREE) + ADDR_W'(addr_idx);
    assign ram_wr    = do_append && (deg_sel < DEG_W'(MAX_DEGREE));

    bfps_adj_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .addr    (ram_addr),
        .wr_data (neighbor),
        .rd_data (ram_rd_data)
    );

    // neighbor read last cycle is new to this run
    assign enqueue = (state_reg == bfps_pkg::ST_SCAN_CHK) && !visited_reg[ram_rd_data];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        deg_next   = deg_reg;
        k_next     = k_reg;
        node_next  = node_reg;
        unique case (state_reg)
            bfps_pkg::ST_IDLE:
            begin
                if (do_run)
                begin
                    // start vertex goes straight into the queue
                    start_next = vertex;
                    head_next  = '0;
                    tail_next  = (VW+1)'(1);
                    state_next = bfps_pkg::ST_VISIT;
                end
            end
            bfps_pkg::ST_VISIT:
            begin
                if (head_reg == tail_reg)
                begin
                    node_next  = '0;
                    state_next = bfps_pkg::ST_EMIT;
                end
                else
                begin
                    cur_next   = head_vert;
                    deg_next   = deg_sel;
                    k_next     = '0;
                    head_next  = head_reg + (VW+1)'(1);
                    state_next = bfps_pkg::ST_SCAN_RD;
                end
            end
            bfps_pkg::ST_SCAN_RD:
            begin
                if (k_reg == deg_reg)
                begin
                    state_next = bfps_pkg::ST_VISIT;
                end
                else
                begin
                    k_next     = k_reg + DEG_W'(1);
                    state_next = bfps_pkg::ST_SCAN_CHK;
                end
            end
            bfps_pkg::ST_SCAN_CHK:
            begin
                if (enqueue)
                begin
                    tail_next = tail_reg + (VW+1)'(1);
                end
                state_next = bfps_pkg::ST_SCAN_RD;
            end
            bfps_pkg::ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (node_reg == bfps_pkg::vertex_t'(NV - 1))
                    begin
                        state_next = bfps_pkg::ST_IDLE;
                    end
                    else
                    begin
                        node_next = node_reg + bfps_pkg::vertex_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = bfps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfps_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    // payload registers of the walk
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        start_reg <= start_next;
        deg_reg   <= deg_next;
        k_reg     <= k_next;
        node_reg  <= node_next;
    end

    // degree counts: cleared by reset and by a clear transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                degree_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < NV; i++)
            begin
                degree_reg[i] <= '0;
            end
        end
        else if (ram_wr)
        begin
            degree_reg[vertex] <= deg_sel + DEG_W'(1);
        end
    end

    // visit marks: a run starts with only its start vertex marked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
        end
        else if (do_run)
        begin
            visited_reg <= NV'(1) << vertex;
        end
        else if (enqueue)
        begin
            visited_reg[ram_rd_data] <= 1'b1;
        end
    end

    // parent and queue entries, only read once written in the current run
    always_ff @(posedge clk)
    begin
        if (do_run)
        begin
            fifo_reg[0] <= vertex;
        end
        else if (enqueue)
        begin
            fifo_reg[tail_reg[VW-1:0]] <= ram_rd_data;
            parent_reg[ram_rd_data]    <= cur_reg;
        end
    end

    // result fields follow the node counter, which holds while stalled
    assign out_valid = (state_reg == bfps_pkg::ST_EMIT);
    assign out_xfer  = out_valid && !out_stall;
    assign node      = node_reg;
    assign last      = (node_reg == bfps_pkg::vertex_t'(NV - 1));

    always_comb
    begin
        priority if (node_reg == start_reg)
        begin
            parent_node = '0;
            node_status = bfps_pkg::STAT_ROOT;
        end
        else if (visited_reg[node_reg])
        begin
            parent_node = parent_reg[node_reg];
            node_status = bfps_pkg::STAT_REACHED;
        end
        else
        begin
            parent_node = '0;
            node_status = bfps_pkg::STAT_UNREACHED;
        end
    end

endmodule
